// File: design/fsqrt_pkg.sv
// fsqrt_pkg: constants and types for the binary32 square root pipeline.
// No dependencies.
`default_nettype none
package fsqrt_pkg;
  localparam int unsigned RootStages = 24;   // one root bit per stage
  localparam int unsigned RemW = 26;

  localparam logic [31:0] ExpMask    = 32'h7f80_0000;
  localparam logic [31:0] FracMask   = 32'h007f_ffff;
  localparam logic [31:0] SignBit    = 32'h8000_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;
  localparam logic [31:0] DefaultNan = 32'h7fc0_0000;

  typedef enum logic [1:0] {
    RM_NEAREST = 2'd0,
    RM_ZERO    = 2'd1,
    RM_DOWN    = 2'd2,
    RM_UP      = 2'd3
  } round_mode_t;

  // Leading-zero count of a 23-bit fraction (nonzero).
  function automatic logic [4:0] lzc23(input logic [22:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd0;
    found = 1'b0;
    for (int i = 22; i >= 0; i--) begin
      if (!found && v[i]) begin
        found = 1'b1;
        n = 5'(22 - i);
      end
    end
    return n;
  endfunction
endpackage
`default_nettype wire

// File: design/fsqrt_if.sv
// fsqrt_if: valid/ready channel carrying one payload struct.
// Depends on nothing; payload type given as a parameter.
`default_nettype none
interface fsqrt_if #(parameter type payload_t = logic [31:0]) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/float32_square_root.sv
// float32_square_root: pipelined binary32 square root; depends on fsqrt_pkg, fsqrt_if.
// Pipeline: 1 unpack register, 24 restoring root stages of one bit each,
// rounding folded into the output register.
// Throughput: one operand per cycle; the whole pipe advances on out_ready
// or while its output stage is empty. Synchronous active-low reset clears
// valid bits and rounding_mode (nearest even).
`default_nettype none
module float32_square_root
  import fsqrt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  fsqrt_if.sink            in_ch,    // data: operand_bits
  fsqrt_if.source          out_ch,   // data: {root_bits, invalid_flag, inexact_flag}
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata
);
  // Restoring root: each stage decides one bit of q from the 26-bit
  // partial remainder and the next two radicand bits.
  typedef struct packed {
    logic [47:0]     rad;    // remaining radicand bits, msb first
    logic [RemW-1:0] rem;
    logic [23:0]     q;
    logic [7:0]      exp;    // biased result exponent
    logic            spec;   // special result, bypasses rounding
    logic [31:0]     sres;
    logic            sinv;
    logic [1:0]      rm;
  } stage_t;

  logic [1:0] rm_r;
  always_ff @(posedge clk) begin
    if (!rst_n) rm_r <= RM_NEAREST;
    else if (cfg_we) rm_r <= cfg_wdata;
  end

  logic adv;
  logic out_v_r;
  assign adv = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---- unpack stage
  logic [31:0] x;
  stage_t      s0_nxt;
  logic [4:0]  lz;
  logic [23:0] sig;
  logic [9:0]  bexp;   // signed-ish biased exponent, offset handled below
  logic [9:0]  ue;
  assign x = in_ch.data;
  always_comb begin
    lz = lzc23(x[22:0]);
    s0_nxt = '0;
    s0_nxt.rm = rm_r;
    if (x[30:23] == 8'd0) begin
      sig = 24'({x[22:0], 1'b0} << lz);
      bexp = 10'd1 - 10'(lz) - 10'd1; // exponent of normalized value
    end else begin
      sig = {1'b1, x[22:0]};
      bexp = {2'b00, x[30:23]};
    end
    // bexp+127 keeps it positive; odd unbiased when bexp even
    ue = bexp + 10'd127;                 // = unbiased + 254
    if (!ue[0]) begin
      s0_nxt.rad = {1'b0, sig, 23'd0};
      s0_nxt.exp = 8'((ue >> 1) - 10'd0);
    end else begin
      s0_nxt.rad = {sig, 24'd0};
      s0_nxt.exp = 8'((ue - 10'd1) >> 1);
    end
    // ue = e+254 with e unbiased; result exp = floor(e/2)+127 = (ue>>1)
    if ((x & ~SignBit) == 32'd0 || x == ExpMask) begin
      s0_nxt.spec = 1'b1; s0_nxt.sres = x;
    end else if ((x & ExpMask) == ExpMask && (x & FracMask) != 32'd0) begin
      s0_nxt.spec = 1'b1; s0_nxt.sres = x | QuietBit; s0_nxt.sinv = !x[22];
    end else if (x[31]) begin
      s0_nxt.spec = 1'b1; s0_nxt.sres = DefaultNan; s0_nxt.sinv = 1'b1;
    end
  end

  stage_t pipe_r [RootStages+1];
  logic   v_r    [RootStages+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= RootStages; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_ch.valid;
      for (int i = 1; i <= RootStages; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) pipe_r[0] <= s0_nxt;
  end

  for (genvar g = 1; g <= RootStages; g++) begin : g_root
    stage_t          p;
    stage_t          n;
    logic [RemW-1:0] trial;
    logic [RemW-1:0] rsh;
    assign p = pipe_r[g-1];
    always_comb begin
      n = p;
      rsh = {p.rem[RemW-3:0], p.rad[47:46]};
      trial = {p.q[23:0], 2'b01};
      n.rad = {p.rad[45:0], 2'b00};
      if (rsh >= trial) begin
        n.rem = rsh - trial;
        n.q = {p.q[22:0], 1'b1};
      end else begin
        n.rem = rsh;
        n.q = {p.q[22:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (adv) pipe_r[g] <= n;
    end
  end

  // ---- round stage
  stage_t      f;
  logic        inexact;
  logic        inc;
  logic [33:0] res_nxt;
  assign f = pipe_r[RootStages];
  always_comb begin
    inexact = f.rem != '0;
    inc = 1'b0;
    if (inexact) begin
      case (round_mode_t'(f.rm))
        RM_NEAREST: inc = f.rem > RemW'(f.q);
        RM_UP:      inc = 1'b1;
        default:    inc = 1'b0;
      endcase
    end
    if (f.spec) res_nxt = {f.sres, f.sinv, 1'b0};
    else res_nxt = {({1'b0, f.exp, 23'd0} + {8'd0, f.q} - 32'h0080_0000
                     + 32'(inc)), 1'b0, inexact};
  end

  logic [33:0] out_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (adv) out_v_r <= v_r[RootStages];
  end
  always_ff @(posedge clk) begin
    if (adv) out_r <= res_nxt;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;
endmodule
`default_nettype wire
